// ----- design/utf8d_pkg.sv -----
// Shared types and constants for the UTF-8 byte stream decoder.
// No dependencies; used by utf8d_step and the top level.
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CpW   = 21;

	// Top nibble of a lead byte
	localparam logic [3:0] LEAD4_NIB  = 4'hF;
	localparam logic [3:0] LEAD3_NIB  = 4'hE;
	localparam logic [3:0] LEAD2A_NIB = 4'hC;
	localparam logic [3:0] LEAD2B_NIB = 4'hD;

	// Continuation bytes still expected
	localparam logic [1:0] PEND_NONE  = 2'd0;
	localparam logic [1:0] PEND_ONE   = 2'd1;
	localparam logic [1:0] PEND_TWO   = 2'd2;
	localparam logic [1:0] PEND_THREE = 2'd3;

	typedef struct packed {
		logic [1:0]     pending;
		logic [CpW-1:0] partial;
	} dec_state_t;

	typedef struct packed {
		logic           emit;
		logic [CpW-1:0] codepoint;
		logic           truncated;
	} dec_result_t;

endpackage

`default_nettype wire

// ----- design/utf8d_step.sv -----
// One decode step: current sequence state and one byte in, next state and result out.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_step (
	input  wire logic [utf8d_pkg::ByteW-1:0] byte_in,
	input  wire utf8d_pkg::dec_state_t       cur,
	output utf8d_pkg::dec_state_t            nxt,
	output utf8d_pkg::dec_result_t           res
);

	logic [3:0]                  nib;
	logic [1:0]                  pend_dec;
	logic [utf8d_pkg::CpW-1:0]   merged;

	assign nib      = byte_in[7:4];
	assign pend_dec = cur.pending - 2'd1;

	// place the six payload bits of a continuation byte
	always_comb begin
		merged = cur.partial;
		unique case (pend_dec)
			utf8d_pkg::PEND_NONE: merged[5:0]   = cur.partial[5:0]   | byte_in[5:0];
			utf8d_pkg::PEND_ONE:  merged[11:6]  = cur.partial[11:6]  | byte_in[5:0];
			utf8d_pkg::PEND_TWO:  merged[17:12] = cur.partial[17:12] | byte_in[5:0];
			default:              merged        = cur.partial;
		endcase
	end

	always_comb begin
		nxt           = cur;
		res.emit      = 1'b0;
		res.codepoint = '0;
		res.truncated = 1'b0;
		if (cur.pending == utf8d_pkg::PEND_NONE) begin
			if (byte_in != '0) begin
				unique case (nib) inside
					utf8d_pkg::LEAD4_NIB: begin
						nxt.pending = utf8d_pkg::PEND_THREE;
						nxt.partial = {byte_in[2:0], 18'd0};
					end
					utf8d_pkg::LEAD3_NIB: begin
						nxt.pending = utf8d_pkg::PEND_TWO;
						nxt.partial = {5'd0, byte_in[3:0], 12'd0};
					end
					utf8d_pkg::LEAD2A_NIB, utf8d_pkg::LEAD2B_NIB: begin
						nxt.pending = utf8d_pkg::PEND_ONE;
						nxt.partial = {10'd0, byte_in[4:0], 6'd0};
					end
					default: begin
						res.emit      = 1'b1;
						res.codepoint = {13'd0, byte_in};
					end
				endcase
			end
		end else if (byte_in == '0) begin
			// cut short: hand out what has been gathered
			res.emit      = 1'b1;
			res.codepoint = cur.partial;
			res.truncated = 1'b1;
			nxt.pending   = utf8d_pkg::PEND_NONE;
			nxt.partial   = '0;
		end else begin
			nxt.pending = pend_dec;
			nxt.partial = merged;
			if (pend_dec == utf8d_pkg::PEND_NONE) begin
				res.emit      = 1'b1;
				res.codepoint = merged;
				nxt.partial   = '0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/utf8_byte_stream_decoder_unit.sv -----
// UTF-8 byte stream decoder, top level: input register, decode step, result register.
// Depends on utf8d_pkg and utf8d_step.
//
// Usage:
//   Byte channel: byte_valid / byte_stall / byte_in. One byte of a NUL-terminated
//   string per request; a byte is taken at a clock edge with byte_valid high and
//   byte_stall low.
//   Code point channel: cp_valid / cp_stall / codepoint / truncated. One request per
//   decoded character, or one with truncated set when a NUL cuts a sequence short.
//   Lead bytes, other continuation bytes and a NUL outside a sequence give none.
//   Throughput: one byte per clock, sustained while cp_stall is low. The only loop is the sequence state
//   (pending count and partial value), updated by one shift-or step per byte.
//   Path: a byte that is taken lands in the input register; its result, if any,
//   is then written to the result register once that slot is free.
//   Stall: while cp_stall holds a waiting result, the input register holds its byte
//   and byte_stall rises only if that register is full, so one byte more is taken.
//   Reset (arst_n low, asynchronous): both registers empty, decoder idle, no
//   partial value.
`timescale 1ns / 1ps
`default_nettype none

module utf8_byte_stream_decoder_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          byte_valid,
	output logic                               byte_stall,
	input  wire logic [utf8d_pkg::ByteW-1:0]   byte_in,
	output logic                               cp_valid,
	input  wire logic                          cp_stall,
	output logic [utf8d_pkg::CpW-1:0]          codepoint,
	output logic                               truncated
);

	logic                          valid_s1;
	logic [utf8d_pkg::ByteW-1:0]   byte_s1;
	logic                          valid_s2;
	logic [utf8d_pkg::CpW-1:0]     cp_s2;
	logic                          trunc_s2;
	utf8d_pkg::dec_state_t         state_q;
	utf8d_pkg::dec_state_t         state_nxt;
	utf8d_pkg::dec_result_t        step_res;
	logic                          out_free;
	logic                          advance;

	// the result slot is free when empty or being taken this cycle
	assign out_free   = !valid_s2 || !cp_stall;
	// decode the held byte once its result has somewhere to go
	assign advance    = valid_s1 && out_free;
	// hold off the sender only when the held byte cannot move on
	assign byte_stall = valid_s1 && !out_free;

	utf8d_step u_step (
		.byte_in (byte_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.res     (step_res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1 <= byte_in;
		end
	end

	// sequence state: advance once per decoded byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && step_res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res.emit) begin
			cp_s2    <= step_res.codepoint;
			trunc_s2 <= step_res.truncated;
		end
	end

	assign cp_valid  = valid_s2;
	assign codepoint = cp_s2;
	assign truncated = trunc_s2;

endmodule

`default_nettype wire
